>>> rtl/wbfhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbfhd_pkg
// Shared types and constants for the weighted FIFO with head drop.
// ----------------------------------------------------------------------------
package wbfhd_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DEPART = 2'd0,
      ST_AUTO   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // Register index (paddr[2])
   localparam logic REG_AUTO_EN = 1'b0;
   localparam logic REG_LIMIT   = 1'b1;

   localparam int         LIMIT_W     = 20;
   localparam int         OCC_W       = 5;
   localparam logic [19:0] LIMIT_RESET = 20'd1000;
   localparam logic [19:0] TOTAL_MAX   = 20'hFFFFF;
   localparam logic [4:0]  OCC_MAX     = 5'd31;

   // Command handed from front to back; weight already masked
   typedef struct packed {
      logic        is_depart;
      logic [15:0] id;
      logic [15:0] weight;
   } cmd_type;

   // Back engine sequencer
   typedef enum logic [1:0] {
      BE_IDLE,
      BE_READ,
      BE_EMIT
   } be_state_type;

endpackage : wbfhd_pkg
`default_nettype wire

>>> rtl/weight_budget_fifo_head_drop_top.sv
// Flow: a reject or an empty depart is answered from the idle state straight into the
//   result register once it is free; a depart or each auto-dispatched entry needs a store
//   read (the store's read port is registered), then an emit that waits while the result
//   is stalled. A plain add is taken while idle and the next command can follow at once.
// Reset: pointers, count, total, queue and result valid clear; enable 0,
//   limit 1000; store contents stay undefined until written.
`default_nettype none
// ----------------------------------------------------------------------------
// weight_budget_fifo_head_drop_top
// FIFO of (id, weight) entries with a running weight total and head drop
// when the total exceeds a programmable limit.
// ----------------------------------------------------------------------------
module weight_budget_fifo_head_drop_top
   import wbfhd_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_entry_id,
   input  logic [15:0] req_entry_weight,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_id,
   output logic [15:0] rsp_out_weight,
   output logic [19:0] rsp_total_after,
   output logic [4:0]  rsp_occupancy,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Stored weight width: input field is 16 bits, masked to WEIGHT_BITS (at most 16)
   localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

   // ---------------------------------------------------------------------
   // Registers: auto-dispatch enable at 0x0, weight limit at 0x4
   // ---------------------------------------------------------------------
   logic        auto_en_ff, auto_en_in;
   logic [19:0] limit_ff, limit_in;
   logic        cfg_wr;
   logic        reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_comb begin
      auto_en_in = auto_en_ff;
      limit_in   = limit_ff;
      if (cfg_wr) begin
         if (reg_sel == REG_AUTO_EN) begin
            auto_en_in = pwdata[0];
         end else begin
            limit_in = pwdata[19:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_en_ff <= 1'b0;
         limit_ff   <= LIMIT_RESET;
      end else begin
         auto_en_ff <= auto_en_in;
         limit_ff   <= limit_in;
      end
   end

   assign prdata = (reg_sel == REG_LIMIT) ? {12'd0, limit_ff} : {31'd0, auto_en_ff};

   // ---------------------------------------------------------------------
   // Front: decode + two-deep command queue, so the input side keeps
   // taking transactions, until the queue is full, while the engine works or the output is stalled.
   // ---------------------------------------------------------------------
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   wbfhd_front #(
      .WB (WB)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_entry_id     (req_entry_id),
      .req_entry_weight (req_entry_weight),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   // ---------------------------------------------------------------------
   // Back: store, total, dispatch loop and result register
   // ---------------------------------------------------------------------
   wbfhd_back #(
      .DEPTH (DEPTH),
      .WB    (WB)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .auto_en         (auto_en_ff),
      .limit           (limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_weight  (rsp_out_weight),
      .rsp_total_after (rsp_total_after),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_last        (rsp_last)
   );

endmodule : weight_budget_fifo_head_drop_top
`default_nettype wire

>>> rtl/wbfhd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbfhd_front
// Input side: takes transactions, decodes them into commands and holds
// them in a two-entry queue for the back engine.
// ----------------------------------------------------------------------------
module wbfhd_front
   import wbfhd_pkg::*;
#(
   parameter int WB = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_entry_id,
   input  logic [15:0] req_entry_weight,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_pop
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    cmd_in;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   // Decode: weight taken in its low WB bits
   always_comb begin
      cmd_in.is_depart = req_action;
      cmd_in.id        = req_entry_id;
      cmd_in.weight    = 16'(req_entry_weight[WB-1:0]);
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule : wbfhd_front
`default_nettype wire

>>> rtl/wbfhd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbfhd_back
// Back engine: entry store, pointers, running total and result register.
// Removes head entries one per visit of the read/emit pair.
// ----------------------------------------------------------------------------
module wbfhd_back
   import wbfhd_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WB    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   input  logic        auto_en,
   input  logic [19:0] limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_id,
   output logic [15:0] rsp_out_weight,
   output logic [19:0] rsp_total_after,
   output logic [4:0]  rsp_occupancy,
   output logic        rsp_last
);

   localparam int PW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int TW   = WB + CNTW;
   localparam int CW   = (TW > LIMIT_W) ? TW : LIMIT_W;
   localparam int OW   = (CNTW > OCC_W) ? CNTW : OCC_W;
   localparam int MW   = 16 + WB;

   // Entry store {id, weight}
   logic [MW-1:0]   mem [DEPTH];
   logic [MW-1:0]   rd_data_ff;

   be_state_type    state_ff, state_in;
   status_type      mode_ff, mode_in;
   logic [PW-1:0]   head_ff, head_in;
   logic [PW-1:0]   tail_ff, tail_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [TW-1:0]   total_ff, total_in;

   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   logic [15:0]     rsp_id_ff, rsp_id_in;
   logic [15:0]     rsp_w_ff, rsp_w_in;
   logic [TW-1:0]   rsp_total_ff, rsp_total_in;
   logic [CNTW-1:0] rsp_count_ff, rsp_count_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            out_free, load_rsp, mem_we;
   logic            full, empty, over_add, more;
   logic [WB-1:0]   cmd_w, head_w;
   logic [15:0]     head_id;
   logic [TW-1:0]   add_total, pop_total;
   logic [CNTW-1:0] pop_count;
   logic [PW-1:0]   head_nxt, tail_nxt;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_w     = cmd.weight[WB-1:0];
   assign head_w    = rd_data_ff[WB-1:0];
   assign head_id   = rd_data_ff[MW-1:WB];
   assign full      = (count_ff == CNTW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign add_total = total_ff + TW'(cmd_w);
   assign pop_total = total_ff - TW'(head_w);
   assign pop_count = count_ff - CNTW'(1);
   assign over_add  = auto_en && (CW'(add_total) > CW'(limit));
   assign more      = (mode_ff == ST_AUTO) && auto_en &&
                      (CW'(pop_total) > CW'(limit)) && (pop_count != '0);
   assign head_nxt  = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
   assign tail_nxt  = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + PW'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE: begin
            if (cmd_valid) begin
               if (cmd.is_depart) begin
                  if (!empty) state_in = BE_READ;
               end else if (!full && over_add) begin
                  state_in = BE_READ;
               end
            end
         end
         BE_READ: state_in = BE_EMIT;
         BE_EMIT: begin
            if (out_free) state_in = more ? BE_READ : BE_IDLE;
         end
         default: state_in = BE_IDLE;
      endcase
   end

   // Datapath control
   always_comb begin
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      load_rsp      = 1'b0;
      mode_in       = mode_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rsp_status_in = ST_EMPTY;
      rsp_id_in     = cmd.id;
      rsp_w_in      = 16'(cmd_w);
      rsp_total_in  = total_ff;
      rsp_count_in  = count_ff;
      rsp_last_in   = 1'b1;
      case (state_ff)
         BE_IDLE: begin
            if (cmd_valid) begin
               if (cmd.is_depart) begin
                  if (!empty) begin
                     cmd_pop = 1'b1;
                     mode_in = ST_DEPART;
                  end else if (out_free) begin
                     cmd_pop       = 1'b1;
                     load_rsp      = 1'b1;
                     rsp_status_in = ST_EMPTY;
                     rsp_id_in     = '0;
                     rsp_w_in      = '0;
                  end
               end else if (!full) begin
                  cmd_pop  = 1'b1;
                  mem_we   = 1'b1;
                  mode_in  = ST_AUTO;
                  tail_in  = tail_nxt;
                  count_in = count_ff + CNTW'(1);
                  total_in = add_total;
               end else if (out_free) begin
                  // reject echoes the masked input
                  cmd_pop       = 1'b1;
                  load_rsp      = 1'b1;
                  rsp_status_in = ST_FULL;
               end
            end
         end
         BE_EMIT: begin
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_status_in = mode_ff;
               rsp_id_in     = head_id;
               rsp_w_in      = 16'(head_w);
               rsp_total_in  = pop_total;
               rsp_count_in  = pop_count;
               rsp_last_in   = !more;
               head_in       = head_nxt;
               count_in      = pop_count;
               total_in      = pop_total;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         mode_ff      <= ST_DEPART;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_w_ff      <= rsp_w_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // Store: one write port at tail, registered read at head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= {cmd.id, cmd_w};
      end
      rd_data_ff <= mem[head_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_out_weight  = rsp_w_ff;
   assign rsp_total_after = (CW'(rsp_total_ff) > CW'(TOTAL_MAX)) ? TOTAL_MAX
                                                                 : 20'(rsp_total_ff);
   assign rsp_occupancy   = (OW'(rsp_count_ff) > OW'(OCC_MAX)) ? OCC_MAX
                                                               : 5'(rsp_count_ff);
   assign rsp_last        = rsp_last_ff;

endmodule : wbfhd_back
`default_nettype wire

>>> rtl/wbfhd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbfhd_checker
// Port-level checks on the weighted FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module wbfhd_checker
   import wbfhd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_out_id,
   input logic [15:0] rsp_out_weight,
   input logic [4:0]  rsp_occupancy,
   input logic        rsp_last
);

   localparam logic [4:0] OCC_FULL = (DEPTH > 31) ? OCC_MAX : 5'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_id) &&
                                 $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_out_id == 16'd0 && rsp_out_weight == 16'd0 && rsp_occupancy == 5'd0)
      else $error("empty depart result not zero");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_occupancy == OCC_FULL)
      else $error("reject while store not full");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DEPART || rsp_status == ST_EMPTY ||
                    rsp_status == ST_FULL) |-> rsp_last)
      else $error("single-result transaction without last");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or queue not cleared by reset");

endmodule : wbfhd_checker

bind weight_budget_fifo_head_drop_top wbfhd_checker #(.DEPTH(DEPTH)) u_wbfhd_checker (.*);
`default_nettype wire
